// ===== hdl/ursd_pkg.sv =====
// Shared types, register indexes, reset values and the segment decoder for the ranging core.
package ursd_pkg;

	localparam int MeasureW = 24;
	localparam int TimeoutW = 20;
	localparam int ScanW    = 16;
	localparam int DistW    = 15;
	localparam int CfgW     = 24;
	localparam int CfgAddrW = 2;
	localparam int RemW     = 9;
	localparam int CmStep   = 10;
	localparam int CmDiv    = 291;

	localparam logic [CfgAddrW-1:0] REG_MEASURE_PERIOD = 2'd0;
	localparam logic [CfgAddrW-1:0] REG_ECHO_TIMEOUT   = 2'd1;
	localparam logic [CfgAddrW-1:0] REG_DIGIT_PERIOD   = 2'd2;

	localparam logic [MeasureW-1:0] MEASURE_PERIOD_RESET = 24'd1000000;
	localparam logic [TimeoutW-1:0] ECHO_TIMEOUT_RESET   = 20'd1000000;
	localparam logic [ScanW-1:0]    DIGIT_PERIOD_RESET   = 16'd1000;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_TRIG,
		PH_WAIT,
		PH_PULSE
	} phase_t;

	typedef struct packed {
		logic              trigger;
		logic              reading_done;
		logic              timed_out;
		logic [DistW-1:0]  distance_cm;
	} rng_status_t;

	typedef struct packed {
		logic [3:0] digit_enable;
		logic [6:0] segments;
	} disp_out_t;

	function automatic logic [6:0] seg_of(input logic [3:0] digit);
		logic [6:0] seg;
		unique case (digit)
			4'd0: seg = 7'h40;
			4'd1: seg = 7'h79;
			4'd2: seg = 7'h24;
			4'd3: seg = 7'h30;
			4'd4: seg = 7'h19;
			4'd5: seg = 7'h12;
			4'd6: seg = 7'h02;
			4'd7: seg = 7'h78;
			4'd8: seg = 7'h00;
			4'd9: seg = 7'h18;
			default: seg = 7'h7F;
		endcase
		return seg;
	endfunction

endpackage

// ===== hdl/ursd_ranger.sv =====
// Trigger sequencer, echo pulse timer and running centimeter and decimal digit counters.
module ursd_ranger #(
	parameter int NUM_DIGITS = 4,
	parameter int TRIGGER_HIGH_TICKS = 10,
	parameter int TRIGGER_LOW_TICKS = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic                                echo,
	input  logic [ursd_pkg::MeasureW-1:0]        measure_period,
	input  logic [ursd_pkg::TimeoutW-1:0]        echo_timeout,
	output logic                                load,
	output logic [NUM_DIGITS-1:0][3:0]          load_digits,
	output ursd_pkg::rng_status_t               status
);
	import ursd_pkg::*;

	localparam logic [MeasureW-1:0] TrigLow  = MeasureW'(TRIGGER_LOW_TICKS);
	localparam logic [MeasureW-1:0] TrigEnd  = MeasureW'(TRIGGER_LOW_TICKS + TRIGGER_HIGH_TICKS);
	localparam logic [MeasureW-1:0] TrigLast =
		MeasureW'(TRIGGER_LOW_TICKS + TRIGGER_HIGH_TICKS - 1);
	localparam logic [MeasureW-1:0] MaxPeriod = '1;
	localparam logic [TimeoutW-1:0] MaxWait = '1;

	phase_t                     phase_q, phase_n;
	logic [MeasureW-1:0]        period_q, period_n, c;
	logic [TimeoutW-1:0]        wait_q, wait_n;
	logic [TimeoutW-1:0]        width_q, width_n;
	logic [RemW-1:0]            rem_q, rem_n, rem_sum;
	logic [DistW-1:0]           cm_q, cm_n;
	logic [NUM_DIGITS-1:0][3:0] bcd_q, bcd_n;
	logic [DistW-1:0]           dist_q, dist_n;
	logic                       tmo_q, tmo_n;
	logic                       trig, done, carry;

	always_comb begin
		c = period_q;
		phase_n = phase_q;
		wait_n = wait_q;
		width_n = width_q;
		rem_n = rem_q;
		cm_n = cm_q;
		bcd_n = bcd_q;
		dist_n = dist_q;
		tmo_n = tmo_q;
		trig = 1'b0;
		done = 1'b0;
		load = 1'b0;
		load_digits = bcd_q;
		rem_sum = rem_q + RemW'(CmStep);
		carry = 1'b0;

		if (phase_q == PH_IDLE && c >= measure_period) begin
			c = '0;
			phase_n = PH_TRIG;
		end

		if (phase_n == PH_TRIG) begin
			if (c >= TrigLow && c < TrigEnd) begin
				trig = 1'b1;
			end
			if (c >= TrigLast) begin
				phase_n = PH_WAIT;
				wait_n = '0;
				width_n = '0;
				rem_n = '0;
				cm_n = '0;
				bcd_n = '0;
			end
		end else if (phase_n == PH_WAIT || phase_n == PH_PULSE) begin
			if (phase_n == PH_PULSE && !echo) begin
				load = 1'b1;
				load_digits = bcd_q;
				dist_n = cm_q;
				tmo_n = 1'b0;
				done = 1'b1;
				phase_n = PH_IDLE;
			end else begin
				if (wait_q != MaxWait) begin
					wait_n = wait_q + 1'b1;
				end
				if (echo) begin
					if (phase_n == PH_WAIT) begin
						phase_n = PH_PULSE;
						width_n = TimeoutW'(1);
						rem_n = '0;
						cm_n = '0;
						bcd_n = '0;
					end else if (width_q != MaxWait) begin
						width_n = width_q + 1'b1;
						if (width_q[0]) begin
							if (rem_sum >= RemW'(CmDiv)) begin
								rem_n = rem_sum - RemW'(CmDiv);
								cm_n = cm_q + 1'b1;
								carry = 1'b1;
								for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
									if (carry) begin
										if (bcd_q[i] == 4'd9) begin
											bcd_n[i] = 4'd0;
										end else begin
											bcd_n[i] = bcd_q[i] + 1'b1;
											carry = 1'b0;
										end
									end
								end
							end else begin
								rem_n = rem_sum;
							end
						end
					end
				end
				if (wait_n >= echo_timeout) begin
					load = 1'b1;
					load_digits = '0;
					dist_n = '0;
					tmo_n = 1'b1;
					done = 1'b1;
					phase_n = PH_IDLE;
				end
			end
		end

		period_n = (c != MaxPeriod) ? c + 1'b1 : MaxPeriod;

		status.trigger = trig;
		status.reading_done = done;
		status.timed_out = tmo_n;
		status.distance_cm = dist_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			period_q <= '0;
			wait_q <= '0;
			width_q <= '0;
			rem_q <= '0;
			cm_q <= '0;
			bcd_q <= '0;
			dist_q <= '0;
			tmo_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			period_q <= period_n;
			wait_q <= wait_n;
			width_q <= width_n;
			rem_q <= rem_n;
			cm_q <= cm_n;
			bcd_q <= bcd_n;
			dist_q <= dist_n;
			tmo_q <= tmo_n;
		end
	end

endmodule

// ===== hdl/ursd_display.sv =====
// Digit store, scan timer and seven-segment decode for the multiplexed display.
module ursd_display #(
	parameter int NUM_DIGITS = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  logic                             load,
	input  logic [NUM_DIGITS-1:0][3:0]       load_digits,
	input  logic [ursd_pkg::ScanW-1:0]        digit_period,
	output ursd_pkg::disp_out_t              disp
);
	import ursd_pkg::*;

	localparam int IdxW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_DIGITS - 1);

	logic [NUM_DIGITS-1:0][3:0] shown_q, shown_n;
	logic [ScanW-1:0]           scan_q, scan_n;
	logic [ScanW:0]             scan_inc;
	logic [IdxW-1:0]            idx_q, idx_n;
	logic [3:0]                 digit;

	always_comb begin
		shown_n = load ? load_digits : shown_q;
		digit = shown_n[idx_q];
		disp.segments = seg_of(digit);
		for (int k = 0; k < 4; k++) begin
			disp.digit_enable[k] = (int'(idx_q) == k);
		end

		scan_inc = {1'b0, scan_q} + 1'b1;
		scan_n = scan_inc[ScanW-1:0];
		idx_n = idx_q;
		if (scan_inc >= {1'b0, digit_period}) begin
			scan_n = '0;
			idx_n = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q <= '0;
			scan_q <= '0;
			idx_q <= '0;
		end else if (step) begin
			shown_q <= shown_n;
			scan_q <= scan_n;
			idx_q <= idx_n;
		end
	end

endmodule

// ===== hdl/ultrasonic_range_seven_segment_core.sv =====
// Top level of the ultrasonic ranging core with handshake registers and configuration.
//
// Channel   Dir  Beat contents
// s_*       in   one tick: echo level
// m_*       out  one tick: trigger, digit enable, segments, distance, done, timeout flag
// cfg_*     in   register write: index and data
//
// An input beat sits in the input register and its result is computed by short logic
// into the output register.
// A new beat is taken every cycle while the output side keeps up.
// A stalled output holds both stages; the input register refills as soon as it moves.
// Reset clears all counters, the digit store and both handshake stages.
module ultrasonic_range_seven_segment_core #(
	parameter int NUM_DIGITS = 4,
	parameter int TRIGGER_HIGH_TICKS = 10,
	parameter int TRIGGER_LOW_TICKS = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,  // [0] echo_level
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] trigger, [4:1] digit_enable, [11:5] segments, [26:12] distance_cm,
	// [27] reading_done, [28] timed_out
	output logic [31:0]                       m_tdata,
	input  logic                              cfg_we,
	input  logic [ursd_pkg::CfgAddrW-1:0]      cfg_addr,
	input  logic [ursd_pkg::CfgW-1:0]          cfg_data
);
	import ursd_pkg::*;

	logic [MeasureW-1:0]        measure_period_q;
	logic [TimeoutW-1:0]        echo_timeout_q;
	logic [ScanW-1:0]           digit_period_q;
	logic                       valid_s1;
	logic                       echo_s1;
	logic                       advance;
	logic                       load;
	logic [NUM_DIGITS-1:0][3:0] load_digits;
	rng_status_t                status;
	disp_out_t                  disp;
	logic [31:0]                result_s2;

	assign advance = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			measure_period_q <= MEASURE_PERIOD_RESET;
			echo_timeout_q <= ECHO_TIMEOUT_RESET;
			digit_period_q <= DIGIT_PERIOD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MEASURE_PERIOD: measure_period_q <= cfg_data[MeasureW-1:0];
				REG_ECHO_TIMEOUT:   echo_timeout_q <= cfg_data[TimeoutW-1:0];
				REG_DIGIT_PERIOD:   digit_period_q <= cfg_data[ScanW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			echo_s1 <= s_tdata[0];
		end
	end

	ursd_ranger #(
		.NUM_DIGITS(NUM_DIGITS),
		.TRIGGER_HIGH_TICKS(TRIGGER_HIGH_TICKS),
		.TRIGGER_LOW_TICKS(TRIGGER_LOW_TICKS)
	) u_ranger (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.echo(echo_s1),
		.measure_period(measure_period_q),
		.echo_timeout(echo_timeout_q),
		.load(load),
		.load_digits(load_digits),
		.status(status)
	);

	ursd_display #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_display (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.load(load),
		.load_digits(load_digits),
		.digit_period(digit_period_q),
		.disp(disp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= {3'b000, status.timed_out, status.reading_done, status.distance_cm,
				disp.segments, disp.digit_enable, status.trigger};
		end
	end

	assign m_tdata = result_s2;

`ifndef NO_ASSERTIONS
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("Input not ready while the output register is empty.");

	a_enable_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[4:1]))
		else $error("More than one digit enabled.");

	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[27] && m_tdata[28]) |-> (m_tdata[26:12] == '0))
		else $error("Timed-out reading with nonzero distance.");

	a_no_trigger_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[27]) |-> !m_tdata[0])
		else $error("Trigger driven on the beat a reading was latched.");
`endif

endmodule

// ===== dv/ultrasonic_range_seven_segment_core_test.sv =====
// Self-checking testbench for the ultrasonic ranging core with a tick-accurate ranging predictor.
module ultrasonic_range_seven_segment_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ursd_pkg::*;

	localparam int DIGITS = 4;
	localparam int TRIG_LOW = 5;
	localparam int TRIG_HIGH = 10;
	localparam logic [CfgAddrW-1:0] REG_SPARE = 2'd3;

	typedef struct {
		bit        trigger;
		bit [3:0]  digit_enable;
		bit [6:0]  segments;
		bit [14:0] distance_cm;
		bit        reading_done;
		bit        timed_out;
	} tick_output_t;

	class ranging_tick_model;
		bit [23:0]    measure_period;
		bit [19:0]    echo_timeout;
		bit [15:0]    digit_period;
		phase_t       ph;
		bit [23:0]    period_cnt;
		bit [19:0]    wait_cnt;
		bit [19:0]    width_cnt;
		bit [3:0]     digits [DIGITS];
		bit [15:0]    scan_cnt;
		int unsigned  digit_sel;
		bit [14:0]    distance;
		bit           timeout_flag;
		bit [6:0]     seg_code [10];
		tick_output_t outputs_due [$];
		int unsigned  errors;
		int unsigned  beats_seen;

		function new();
			measure_period = 24'd1000000;
			echo_timeout = 20'd1000000;
			digit_period = 16'd1000;
			ph = PH_IDLE;
			period_cnt = '0;
			wait_cnt = '0;
			width_cnt = '0;
			foreach (digits[i]) digits[i] = '0;
			scan_cnt = '0;
			digit_sel = 0;
			distance = '0;
			timeout_flag = 1'b0;
			seg_code = '{7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h18};
			errors = 0;
			beats_seen = 0;
		endfunction

		function int unsigned pending();
			return outputs_due.size();
		endfunction

		function void write_reg(input logic [CfgAddrW-1:0] idx, input bit [23:0] value);
			case (idx)
				REG_MEASURE_PERIOD: measure_period = value;
				REG_ECHO_TIMEOUT:   echo_timeout = value[19:0];
				REG_DIGIT_PERIOD:   digit_period = value[15:0];
				default: ;
			endcase
		endfunction

		function void latch(input int unsigned w, input bit from_timeout);
			int unsigned cm;
			int unsigned n;
			cm = ((w >> 1) * 10) / 291;
			n = cm;
			distance = cm[14:0];
			for (int i = DIGITS - 1; i >= 0; i--) begin
				digits[i] = 4'(n % 10);
				n = n / 10;
			end
			timeout_flag = from_timeout;
			ph = PH_IDLE;
		endfunction

		function void take_tick(input bit echo);
			bit [23:0]    c;
			bit           trig;
			bit           done;
			int unsigned  sc;
			tick_output_t r;
			c = period_cnt;
			trig = 1'b0;
			done = 1'b0;
			if (ph == PH_IDLE && c >= measure_period) begin
				c = '0;
				ph = PH_TRIG;
			end
			if (ph == PH_TRIG) begin
				if (c >= TRIG_LOW && c < TRIG_LOW + TRIG_HIGH)
					trig = 1'b1;
				if (c >= TRIG_LOW + TRIG_HIGH - 1) begin
					ph = PH_WAIT;
					wait_cnt = '0;
					width_cnt = '0;
				end
			end else if (ph == PH_WAIT || ph == PH_PULSE) begin
				if (ph == PH_PULSE && !echo) begin
					latch(width_cnt, 1'b0);
					done = 1'b1;
				end else begin
					if (wait_cnt != '1)
						wait_cnt++;
					if (echo) begin
						if (ph == PH_WAIT) begin
							ph = PH_PULSE;
							width_cnt = 20'd1;
						end else if (width_cnt != '1) begin
							width_cnt++;
						end
					end
					if (wait_cnt >= echo_timeout) begin
						latch(0, 1'b1);
						done = 1'b1;
					end
				end
			end
			period_cnt = (c != '1) ? c + 24'd1 : c;

			r.trigger = trig;
			r.digit_enable = 4'b0001 << digit_sel;
			r.segments = seg_code[digits[digit_sel]];
			r.distance_cm = distance;
			r.reading_done = done;
			r.timed_out = timeout_flag;
			outputs_due.push_back(r);

			sc = scan_cnt + 32'd1;
			if (sc >= digit_period) begin
				sc = 0;
				digit_sel = (digit_sel + 1) % DIGITS;
			end
			scan_cnt = sc[15:0];
		endfunction

		task report(input string msg);
			if (errors < 100)
				$display("MISMATCH at %0t ns: %s", $time, msg);
			errors++;
		endtask

		task compare(input string field, input logic [31:0] got, input bit [31:0] want);
			if (got !== want)
				report($sformatf("beat %0d %s got 0x%0h expected 0x%0h",
					beats_seen, field, got, want));
		endtask

		task check_beat(input logic [31:0] beat);
			tick_output_t r;
			beats_seen++;
			if (outputs_due.size() == 0) begin
				report($sformatf("beat %0d arrived with no tick outstanding", beats_seen));
			end else begin
				r = outputs_due.pop_front();
				compare("trigger", beat[0], r.trigger);
				compare("digit_enable", beat[4:1], r.digit_enable);
				compare("segments", beat[11:5], r.segments);
				compare("distance_cm", beat[26:12], r.distance_cm);
				compare("reading_done", beat[27], r.reading_done);
				compare("timed_out", beat[28], r.timed_out);
				compare("padding", beat[31:29], 0);
			end
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = '0;   // [0] echo_level
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// [0] trigger, [4:1] digit_enable, [11:5] segments, [26:12] distance_cm,
	// [27] reading_done, [28] timed_out
	logic [31:0]         m_tdata;
	logic                cfg_we = 1'b0;
	logic [CfgAddrW-1:0] cfg_addr = '0;
	logic [CfgW-1:0]     cfg_data = '0;

	ranging_tick_model board = new();
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_left = 0;
	int unsigned ticks_sent = 0;

	ultrasonic_range_seven_segment_core #(
		.NUM_DIGITS(DIGITS),
		.TRIGGER_HIGH_TICKS(TRIG_HIGH),
		.TRIGGER_LOW_TICKS(TRIG_LOW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("ultrasonic_range_seven_segment_core verification failed");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				board.check_beat(m_tdata);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_tick(input bit echo);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= {7'd0, 1'($urandom_range(1))};
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, echo};
		do @(posedge clk); while (!s_tready);
		board.take_tick(echo);
		ticks_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic configure(input bit [23:0] period, input bit [19:0] timeout,
			input bit [15:0] scan);
		bit [23:0] spare;
		spare = $urandom;
		cfg_we <= 1'b1;
		cfg_addr <= REG_MEASURE_PERIOD;
		cfg_data <= period;
		@(posedge clk);
		board.write_reg(REG_MEASURE_PERIOD, period);
		cfg_addr <= REG_ECHO_TIMEOUT;
		cfg_data <= 24'(timeout);
		@(posedge clk);
		board.write_reg(REG_ECHO_TIMEOUT, 24'(timeout));
		cfg_addr <= REG_DIGIT_PERIOD;
		cfg_data <= 24'(scan);
		@(posedge clk);
		board.write_reg(REG_DIGIT_PERIOD, 24'(scan));
		cfg_addr <= REG_SPARE;
		cfg_data <= spare;
		@(posedge clk);
		board.write_reg(REG_SPARE, spare);
		cfg_we <= 1'b0;
	endtask

	task automatic noise(input int unsigned n);
		repeat (n) send_tick($urandom_range(1));
	endtask

	// lead: 0 keeps the line low before the wait phase, 1 raises it during the
	// trigger so it is already high when the wait starts, 2 toggles it at random.
	task automatic measure_once(input int unsigned delay, input int unsigned width,
			input int unsigned lead);
		int unsigned k;
		while (board.ph != PH_WAIT) begin
			case (lead)
				1: send_tick(board.ph == PH_TRIG);
				2: send_tick($urandom_range(1));
				default: send_tick(1'b0);
			endcase
		end
		for (k = 0; k < delay && board.ph == PH_WAIT; k++)
			send_tick(1'b0);
		for (k = 0; k < width && board.ph != PH_IDLE; k++)
			send_tick(1'b1);
		if (board.ph == PH_PULSE)
			send_tick(1'b0);
	endtask

	task automatic random_phase(input int unsigned n_ticks);
		int unsigned stop;
		int unsigned pick;
		int unsigned w;
		stop = ticks_sent + n_ticks;
		while (ticks_sent < stop) begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				noise($urandom_range(1, 20));
			end else begin
				if (pick < 60)
					w = $urandom_range(1, 30);
				else if (pick < 84)
					w = $urandom_range(30, 100);
				else if (pick < 94)
					w = $urandom_range(100, 180);
				else
					w = 1000000;
				measure_once($urandom_range(0, 12), w, $urandom_range(2));
			end
		end
	endtask

	task automatic random_config();
		configure($urandom_range(16, 60), $urandom_range(30, 120), $urandom_range(1, 12));
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A zero timeout gives up on the first wait tick, even as the echo rises.
		configure(24'd16, 20'd0, 16'd0);
		measure_once(0, 0, 0);
		send_tick(1'b1);
		wait_idle();
		configure(24'd16, 20'd24, 16'd1);
		measure_once(0, 12, 1);
		measure_once(2, 11, 0);
		measure_once(0, 1, 0);
		measure_once(9, 14, 0);
		measure_once(10, 14, 0);
		wait_idle();
		configure(24'd20, 20'd1048575, 16'd2);
		measure_once(4, 60, 2);
		wait_idle();

		random_config();
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 300;
		random_phase(40);
		wait_idle();

		random_config();
		idle_pct = 62;
		random_phase(40);
		wait_idle();

		random_config();
		idle_pct = 0;
		stall_pct = 62;
		random_phase(40);
		wait_idle();

		random_config();
		idle_pct = 14;
		stall_pct = 14;
		random_phase(40);
		wait_idle();

		idle_pct = 0;
		stall_pct = 0;
		configure(24'hFFFFFF, 20'hFFFFF, 16'hFFFF);
		noise(30);
		wait_idle();
		configure(24'd16, 20'd1, 16'd1);
		measure_once(0, 5, 0);
		measure_once(0, 0, 1);
		wait_idle();
		configure(24'd16, 20'hFFFFF, 16'd3);
		measure_once(3, 60, 0);
		noise(10);
		wait_idle();

		repeat (20) @(posedge clk);
		if (board.pending() != 0)
			board.report($sformatf("%0d expected beats never arrived", board.pending()));
		if (board.errors == 0) begin
			$display("ultrasonic_range_seven_segment_core verification clean");
		end else begin
			$display("ultrasonic_range_seven_segment_core verification failed");
		end
		$finish;
	end

endmodule
